// ===== hw/rtl/tcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcrb_pkg
// Shared constants, codes and control types of the pretrigger capture buffer.
// ----------------------------------------------------------------------------
package tcrb_pkg;

    // sizing
    localparam int STORE_DEPTH        = 1024;
    localparam int POST_TRIGGER_LIMIT = 512;
    localparam int PAYLOAD_WIDTH      = 64;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int PTC_W  = $clog2(POST_TRIGGER_LIMIT + 1);

    // fixed field widths
    localparam int OPCODE_W  = 2;
    localparam int SAMPLE_W  = 64;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    // pop status codes
    localparam logic [STATUS_W-1:0] ST_MORE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LAST   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTPOP = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT       = 2'd2;

    localparam logic signed [VALUE_W-1:0] THR_RESET = 16'sd32767;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_result;
        logic from_ram;
    } tcrb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_read;
    } tcrb_sts_t;

    // ring index advance with wrap
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(STORE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/triggered_capture_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// triggered_capture_ring_buffer_top
// Pretrigger capture ring buffer with threshold trigger and post-trigger stop.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall: opcode push, pop or restart plus the
//   sample fields. Every request gives one result on out_valid/out_stall:
//   popped payload, pop status, trigger and freeze flags and the fill level.
//   Push, restart and a pop of an empty ring have the result registered at the
//   accepting edge. A pop that reads the ring goes through the registered
//   read port of the sample RAM and the S_READ state. A new request
//   is taken in the cycle the result slot empties, so a held result does not
//   block the input unless the receiver stalls it.
//   While out_stall is high the result register holds and in_stall rises
//   once a further result would have nowhere to go.
//   Thresholds and the halt bit are written on cfg_valid/cfg_ready (always
//   ready); the user writes them only while no request is in flight, the block itself does not enforce it.
//   Reset clears the indices, counters, trigger, halt bit and result valid;
//   thresholds come up at their maximum. Sample RAM is not cleared; the fill
//   count keeps stale entries from being read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module triggered_capture_ring_buffer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tcrb_pkg::OPCODE_W-1:0]       opcode,
    input  logic [tcrb_pkg::SAMPLE_W-1:0]       sample_payload,
    input  logic signed [tcrb_pkg::VALUE_W-1:0] torque_request,
    input  logic signed [tcrb_pkg::VALUE_W-1:0] speed_rpm,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcrb_pkg::SAMPLE_W-1:0]       read_payload,
    output logic [tcrb_pkg::STATUS_W-1:0]       pop_status,
    output logic                                trigger_armed,
    output logic                                capture_frozen,
    output logic [tcrb_pkg::ENTRIES_W-1:0]      entries_held,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcrb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tcrb_pkg::*;

    tcrb_cmd_t cmd;
    tcrb_sts_t sts;
    logic      cfg_we;

    // config port never backpressures
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    tcrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tcrb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .sample_payload (sample_payload),
        .torque_request (torque_request),
        .speed_rpm      (speed_rpm),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .read_payload   (read_payload),
        .pop_status     (pop_status),
        .trigger_armed  (trigger_armed),
        .capture_frozen (capture_frozen),
        .entries_held   (entries_held)
    );

endmodule

// ===== hw/rtl/tcrb_ram.sv =====
// ----------------------------------------------------------------------------
// tcrb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tcrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcrb_ctrl
// Request sequencing: accepts a request, waits out the RAM read of a pop,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  tcrb_pkg::tcrb_sts_t sts,
    output tcrb_pkg::tcrb_cmd_t cmd
);
    import tcrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_take;

    // room for a new request in S_IDLE once the result slot is free or draining
    assign can_take = (state_reg == S_IDLE) && (!out_valid_reg || !out_stall);
    assign in_stall = !can_take;

    always_comb
    begin
        state_next      = state_reg;
        cmd.accept      = 1'b0;
        cmd.load_result = 1'b0;
        cmd.from_ram    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (can_take && in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.pop_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.load_result = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.load_result = 1'b1;
                cmd.from_ram    = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        priority if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/tcrb_datapath.sv =====
// ----------------------------------------------------------------------------
// tcrb_datapath
// Ring indices, fill and post-trigger counters, trigger compare, config
// registers, sample RAM and the result register.
// ----------------------------------------------------------------------------
module tcrb_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tcrb_pkg::tcrb_cmd_t                   cmd,
    output tcrb_pkg::tcrb_sts_t                   sts,
    input  logic [tcrb_pkg::OPCODE_W-1:0]         opcode,
    input  logic [tcrb_pkg::SAMPLE_W-1:0]         sample_payload,
    input  logic signed [tcrb_pkg::VALUE_W-1:0]   torque_request,
    input  logic signed [tcrb_pkg::VALUE_W-1:0]   speed_rpm,
    input  logic                                  cfg_we,
    input  logic [tcrb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcrb_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [tcrb_pkg::SAMPLE_W-1:0]         read_payload,
    output logic [tcrb_pkg::STATUS_W-1:0]         pop_status,
    output logic                                  trigger_armed,
    output logic                                  capture_frozen,
    output logic [tcrb_pkg::ENTRIES_W-1:0]        entries_held
);
    import tcrb_pkg::*;

    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTC_W-1:0]  ptc_reg, ptc_next;
    logic              armed_reg, armed_next;
    logic signed [VALUE_W-1:0] torque_thr_reg, torque_thr_next;
    logic signed [VALUE_W-1:0] speed_thr_reg, speed_thr_next;
    logic              halt_reg, halt_next;

    logic [SAMPLE_W-1:0]  payload_reg, payload_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 armed_out_reg;
    logic                 frozen_out_reg;
    logic [ENTRIES_W-1:0] entries_reg;

    logic                     ram_we;
    logic                     ram_re;
    logic [PAYLOAD_WIDTH-1:0] ram_rdata;
    logic                     over_thr;
    logic                     ring_full;
    logic                     is_pop;

    assign is_pop    = (opcode == OP_POP);
    assign over_thr  = (torque_request > torque_thr_reg) || (speed_rpm > speed_thr_reg);
    assign ring_full = (fill_reg == FILL_W'(STORE_DEPTH));

    assign sts.pop_read = is_pop && (fill_reg != '0);
    assign ram_re       = cmd.accept && sts.pop_read;

    // request and config update
    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        fill_next       = fill_reg;
        ptc_next        = ptc_reg;
        armed_next      = armed_reg;
        torque_thr_next = torque_thr_reg;
        speed_thr_next  = speed_thr_reg;
        halt_next       = halt_reg;
        ram_we          = 1'b0;

        if (cmd.accept)
        begin
            unique case (opcode)
                OP_PUSH:
                begin
                    if (!halt_reg)
                    begin
                        // trigger and post-trigger count
                        if (armed_reg)
                        begin
                            if (ptc_reg < PTC_W'(POST_TRIGGER_LIMIT))
                            begin
                                ptc_next = ptc_reg + PTC_W'(1);
                            end
                        end
                        else if (over_thr)
                        begin
                            armed_next = 1'b1;
                        end
                        // store unless the limit is now reached
                        if (ptc_next < PTC_W'(POST_TRIGGER_LIMIT))
                        begin
                            ram_we      = 1'b1;
                            wr_idx_next = next_idx(wr_idx_reg);
                            if (ring_full)
                            begin
                                rd_idx_next = next_idx(rd_idx_reg);
                            end
                            else
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                    end
                end
                OP_POP:
                begin
                    if (fill_reg != '0)
                    begin
                        rd_idx_next = next_idx(rd_idx_reg);
                        fill_next   = fill_reg - FILL_W'(1);
                    end
                end
                OP_RESTART:
                begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    fill_next   = '0;
                    ptc_next    = '0;
                    armed_next  = 1'b0;
                    halt_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TORQUE_THR: torque_thr_next = cfg_data;
                CFG_SPEED_THR:  speed_thr_next  = cfg_data;
                CFG_HALT:       halt_next       = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        if (cmd.from_ram)
        begin
            payload_next = SAMPLE_W'(ram_rdata);
            status_next  = (fill_reg == '0) ? ST_LAST : ST_MORE;
        end
        else
        begin
            payload_next = '0;
            status_next  = is_pop ? ST_EMPTY : ST_NOTPOP;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            fill_reg       <= '0;
            ptc_reg        <= '0;
            armed_reg      <= 1'b0;
            torque_thr_reg <= THR_RESET;
            speed_thr_reg  <= THR_RESET;
            halt_reg       <= 1'b0;
        end
        else
        begin
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            fill_reg       <= fill_next;
            ptc_reg        <= ptc_next;
            armed_reg      <= armed_next;
            torque_thr_reg <= torque_thr_next;
            speed_thr_reg  <= speed_thr_next;
            halt_reg       <= halt_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            payload_reg    <= payload_next;
            status_reg     <= status_next;
            armed_out_reg  <= armed_next;
            frozen_out_reg <= (ptc_next >= PTC_W'(POST_TRIGGER_LIMIT));
            entries_reg    <= ENTRIES_W'(fill_next);
        end
    end

    tcrb_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (sample_payload[PAYLOAD_WIDTH-1:0]),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign read_payload   = payload_reg;
    assign pop_status     = status_reg;
    assign trigger_armed  = armed_out_reg;
    assign capture_frozen = frozen_out_reg;
    assign entries_held   = entries_reg;

endmodule

// ===== hw/rtl/tcrb_checker.sv =====
// ----------------------------------------------------------------------------
// tcrb_checker
// Port-level checks of the capture buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tcrb_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [tcrb_pkg::SAMPLE_W-1:0]       read_payload,
    input logic [tcrb_pkg::STATUS_W-1:0]       pop_status,
    input logic                                trigger_armed,
    input logic                                capture_frozen,
    input logic [tcrb_pkg::ENTRIES_W-1:0]      entries_held
);
    import tcrb_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_payload)
            && $stable(pop_status) && $stable(entries_held))
        else $error("result changed while stalled");

    // an empty pop returns no data and an empty ring
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pop_status == ST_EMPTY) |-> (read_payload == '0)
            && (entries_held == '0))
        else $error("empty pop with data or entries");

    // the last pop leaves the ring empty, a pop with more left does not
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((pop_status == ST_LAST) || (pop_status == ST_MORE))
            |-> ((pop_status == ST_LAST) == (entries_held == '0)))
        else $error("pop status disagrees with fill level");

    // freezing only follows a trigger, and the fill level stays within the ring depth
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && capture_frozen |-> trigger_armed
            && (entries_held <= ENTRIES_W'(STORE_DEPTH)))
        else $error("frozen without trigger or fill out of range");

endmodule

bind triggered_capture_ring_buffer_top tcrb_checker u_tcrb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_payload   (read_payload),
    .pop_status     (pop_status),
    .trigger_armed  (trigger_armed),
    .capture_frozen (capture_frozen),
    .entries_held   (entries_held)
);
